// ===== src/mlpq_pkg.sv =====
// Shared types and constants for the multilevel priority queue.
// Used by mlpq_front, mlpq_back and multilevel_priority_queue_top.
`default_nettype none

package mlpq_pkg;

  // Input opcode encodings
  localparam logic [1:0] OPC_ENQ    = 2'd0;
  localparam logic [1:0] OPC_DEQ    = 2'd1;
  localparam logic [1:0] OPC_PRO    = 2'd2;
  localparam logic [1:0] OPC_UNUSED = 2'd3;

  // Status encodings
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;
  localparam logic [1:0] ST_NONE  = 2'd3;

  localparam int LEVEL_W  = 3;
  localparam int OPCODE_W = 2;
  localparam int CFG_W    = 4;
  localparam logic [CFG_W-1:0] LEVELS_RESET = 4'd8;

  // Operation after classification by the front end
  typedef enum logic [2:0] {
    OP_ENQ,
    OP_DEQ,
    OP_PRO,
    OP_NOP,
    OP_BAD
  } op_t;

  typedef struct packed {
    op_t                op;
    logic [LEVEL_W-1:0] level;
  } cmd_t;

  // Back-end sequencer states
  typedef enum logic {
    B_IDLE,
    B_WRITE
  } bstate_t;

endpackage

`default_nettype wire

// ===== src/multilevel_priority_queue_top.sv =====
// Multilevel priority queue: one result per transaction; each item in the back
// end takes a registered entry read, then a head/tail/count update.
// An input passes the front queue, the back-end capture and the result register.
// The back end takes a command only when idle; the front queue holds two.
// Reset: all levels empty, all slots free, levels_in_use 8; no clearing pass.
// Depends on mlpq_pkg, mlpq_front and mlpq_back.
`default_nettype none

module multilevel_priority_queue_top #(
  parameter int NUM_LEVELS = 8,
  parameter int CAPACITY   = 64,
  parameter int TAG_WIDTH  = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [mlpq_pkg::OPCODE_W-1:0] opcode,
  input  wire logic [mlpq_pkg::LEVEL_W-1:0]  level,
  input  wire logic [TAG_WIDTH-1:0]          item_tag,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [1:0]                         status,
  output logic [TAG_WIDTH-1:0]               out_tag,
  output logic                               any_waiting,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [mlpq_pkg::CFG_W-1:0]    cfg_data
);

  localparam int LCW = $clog2(NUM_LEVELS + 1);

  logic [mlpq_pkg::CFG_W-1:0] levels_in_use;
  logic [LCW-1:0]             n_active;
  logic                       cmd_valid;
  logic                       cmd_ready;
  mlpq_pkg::cmd_t             cmd;
  logic [TAG_WIDTH-1:0]       cmd_tag;

  // Configuration register
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) levels_in_use <= mlpq_pkg::LEVELS_RESET;
    else if (cfg_valid) levels_in_use <= cfg_data;
  end

  // Active level count, clamped to 1..NUM_LEVELS
  always_comb begin
    if (levels_in_use == '0) n_active = LCW'(1);
    else if (int'(levels_in_use) > NUM_LEVELS) n_active = LCW'(NUM_LEVELS);
    else n_active = LCW'(levels_in_use);
  end

  mlpq_front #(
    .TAG_WIDTH (TAG_WIDTH),
    .LCW       (LCW)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .opcode    (opcode),
    .level     (level),
    .item_tag  (item_tag),
    .n_active  (n_active),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .cmd_tag   (cmd_tag)
  );

  mlpq_back #(
    .NUM_LEVELS (NUM_LEVELS),
    .CAPACITY   (CAPACITY),
    .TAG_WIDTH  (TAG_WIDTH),
    .LCW        (LCW)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .n_active    (n_active),
    .cmd_valid   (cmd_valid),
    .cmd_ready   (cmd_ready),
    .cmd         (cmd),
    .cmd_tag     (cmd_tag),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status      (status),
    .out_tag     (out_tag),
    .any_waiting (any_waiting)
  );

endmodule

`default_nettype wire

// ===== src/mlpq_front.sv =====
// Front end: accepts input transactions, classifies them and holds them
// in a two-entry command queue. Depends on mlpq_pkg.
`default_nettype none

module mlpq_front #(
  parameter int TAG_WIDTH = 16,
  parameter int LCW       = 4
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [mlpq_pkg::OPCODE_W-1:0] opcode,
  input  wire logic [mlpq_pkg::LEVEL_W-1:0]  level,
  input  wire logic [TAG_WIDTH-1:0]          item_tag,
  input  wire logic [LCW-1:0]                n_active,
  output logic                               cmd_valid,
  input  wire logic                          cmd_ready,
  output mlpq_pkg::cmd_t                     cmd,
  output logic [TAG_WIDTH-1:0]               cmd_tag
);

  mlpq_pkg::cmd_t         q_cmd [2];
  logic [TAG_WIDTH-1:0]   q_tag [2];
  logic                   wr_ptr;
  logic                   rd_ptr;
  logic [1:0]             count;
  mlpq_pkg::cmd_t         cls;
  logic                   push;
  logic                   pop;

  // Classify the incoming transaction
  always_comb begin
    cls.level = level;
    unique case (opcode)
      mlpq_pkg::OPC_ENQ: begin
        if (int'(level) >= int'(n_active)) cls.op = mlpq_pkg::OP_BAD;
        else cls.op = mlpq_pkg::OP_ENQ;
      end
      mlpq_pkg::OPC_DEQ: cls.op = mlpq_pkg::OP_DEQ;
      mlpq_pkg::OPC_PRO: cls.op = mlpq_pkg::OP_PRO;
      default:           cls.op = mlpq_pkg::OP_NOP;
    endcase
  end

  assign in_ready  = (count != 2'd2);
  assign cmd_valid = (count != 2'd0);
  assign push      = in_valid && in_ready;
  assign pop       = cmd_valid && cmd_ready;
  assign cmd       = q_cmd[rd_ptr];
  assign cmd_tag   = q_tag[rd_ptr];

  // Queue payload
  always_ff @(posedge clk) begin
    if (push) begin
      q_cmd[wr_ptr] <= cls;
      q_tag[wr_ptr] <= item_tag;
    end
  end

  // Queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

`default_nettype wire

// ===== src/mlpq_back.sv =====
// Back end: level lists, entry memories, free-slot stack and result register.
// Depends on mlpq_pkg.
`default_nettype none

module mlpq_back #(
  parameter int NUM_LEVELS = 8,
  parameter int CAPACITY   = 64,
  parameter int TAG_WIDTH  = 16,
  parameter int LCW        = 4
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic [LCW-1:0]        n_active,
  input  wire logic                  cmd_valid,
  output logic                       cmd_ready,
  input  wire mlpq_pkg::cmd_t        cmd,
  input  wire logic [TAG_WIDTH-1:0]  cmd_tag,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [1:0]                 status,
  output logic [TAG_WIDTH-1:0]       out_tag,
  output logic                       any_waiting
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int LW = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;

  // Entry memories and free-slot stack
  logic [TAG_WIDTH-1:0] tag_mem  [CAPACITY];
  logic [AW-1:0]        link_mem [CAPACITY];
  logic [AW-1:0]        stk_mem  [CAPACITY];
  logic [TAG_WIDTH-1:0] tag_rd;
  logic [AW-1:0]        link_rd;
  logic [AW-1:0]        stk_rd;

  // Level list registers
  logic [AW-1:0] head [NUM_LEVELS];
  logic [AW-1:0] tail [NUM_LEVELS];
  logic [CW-1:0] cnt  [NUM_LEVELS];
  logic [AW-1:0] head_next [NUM_LEVELS];
  logic [AW-1:0] tail_next [NUM_LEVELS];
  logic [CW-1:0] cnt_next  [NUM_LEVELS];

  logic [CW-1:0] stk_cnt;
  logic [CW-1:0] stk_cnt_next;
  logic [CW-1:0] fresh;
  logic [CW-1:0] fresh_next;
  logic [CW-1:0] stk_top;

  mlpq_pkg::bstate_t state;
  mlpq_pkg::bstate_t state_next;
  mlpq_pkg::cmd_t    cur;
  logic [TAG_WIDTH-1:0] cur_tag;
  logic [LW-1:0]     cur_sel;
  logic              cur_found;

  logic [LW-1:0]     sel;
  logic              found;
  logic              take;
  logic              go;

  logic              tag_we;
  logic [AW-1:0]     tag_wa;
  logic              link_we;
  logic [AW-1:0]     link_wa;
  logic [AW-1:0]     link_wd;
  logic              stk_we;
  logic [AW-1:0]     stk_wa;
  logic [AW-1:0]     stk_wd;

  logic [1:0]           status_next;
  logic [TAG_WIDTH-1:0] out_tag_next;
  logic                 waiting_next;

  // Lowest-numbered active level that holds an item
  always_comb begin
    sel   = '0;
    found = 1'b0;
    for (int k = NUM_LEVELS - 1; k >= 0; k--) begin
      if (k < int'(n_active) && cnt[k] != '0) begin
        sel   = LW'(k);
        found = 1'b1;
      end
    end
  end

  assign cmd_ready = (state == mlpq_pkg::B_IDLE);
  assign take      = cmd_valid && cmd_ready;
  assign go        = (state == mlpq_pkg::B_WRITE) && (!out_valid || out_ready);
  assign stk_top   = stk_cnt - CW'(1);

  // Sequencer and update logic
  always_comb begin
    logic [LW-1:0] l;
    logic [AW-1:0] slot;
    int            n;
    state_next   = state;
    stk_cnt_next = stk_cnt;
    fresh_next   = fresh;
    tag_we       = 1'b0;
    tag_wa       = '0;
    link_we      = 1'b0;
    link_wa      = '0;
    link_wd      = '0;
    stk_we       = 1'b0;
    stk_wa       = '0;
    stk_wd       = '0;
    status_next  = mlpq_pkg::ST_OK;
    out_tag_next = '0;
    l            = LW'(cur.level);
    n            = int'(n_active);
    slot         = '0;
    for (int k = 0; k < NUM_LEVELS; k++) begin
      head_next[k] = head[k];
      tail_next[k] = tail[k];
      cnt_next[k]  = cnt[k];
    end

    unique case (state)
      mlpq_pkg::B_IDLE: begin
        if (take) state_next = mlpq_pkg::B_WRITE;
      end
      mlpq_pkg::B_WRITE: begin
        if (go) begin
          state_next = mlpq_pkg::B_IDLE;
          unique case (cur.op)
            mlpq_pkg::OP_ENQ: begin
              if (stk_cnt == '0 && fresh == CW'(CAPACITY)) begin
                status_next = mlpq_pkg::ST_FULL;
              end else begin
                if (stk_cnt != '0) begin
                  slot         = stk_rd;
                  stk_cnt_next = stk_cnt - CW'(1);
                end else begin
                  slot       = fresh[AW-1:0];
                  fresh_next = fresh + CW'(1);
                end
                tag_we = 1'b1;
                tag_wa = slot;
                if (cnt[l] != '0) begin
                  link_we = 1'b1;
                  link_wa = tail[l];
                  link_wd = slot;
                end else begin
                  head_next[l] = slot;
                end
                tail_next[l] = slot;
                cnt_next[l]  = cnt[l] + CW'(1);
              end
            end
            mlpq_pkg::OP_DEQ: begin
              if (!cur_found) begin
                status_next = mlpq_pkg::ST_NONE;
              end else begin
                out_tag_next = tag_rd;
                cnt_next[cur_sel] = cnt[cur_sel] - CW'(1);
                if (cnt[cur_sel] == CW'(1)) begin
                  head_next[cur_sel] = '0;
                  tail_next[cur_sel] = '0;
                end else begin
                  head_next[cur_sel] = link_rd;
                end
                stk_we       = 1'b1;
                stk_wa       = stk_cnt[AW-1:0];
                stk_wd       = head[cur_sel];
                stk_cnt_next = stk_cnt + CW'(1);
              end
            end
            mlpq_pkg::OP_PRO: begin
              if (n > 1) begin
                // level 1 joins the end of level 0
                if (cnt[1] != '0) begin
                  if (cnt[0] == '0) begin
                    head_next[0] = head[1];
                  end else begin
                    link_we = 1'b1;
                    link_wa = tail[0];
                    link_wd = head[1];
                  end
                  tail_next[0] = tail[1];
                  cnt_next[0]  = cnt[0] + cnt[1];
                end
                // higher levels move up one
                for (int k = 1; k < NUM_LEVELS - 1; k++) begin
                  if (k < n - 1) begin
                    head_next[k] = head[k+1];
                    tail_next[k] = tail[k+1];
                    cnt_next[k]  = cnt[k+1];
                  end
                end
                for (int k = 1; k < NUM_LEVELS; k++) begin
                  if (k == n - 1) begin
                    head_next[k] = '0;
                    tail_next[k] = '0;
                    cnt_next[k]  = '0;
                  end
                end
              end
            end
            mlpq_pkg::OP_BAD: status_next = mlpq_pkg::ST_RANGE;
            default:          status_next = mlpq_pkg::ST_OK;
          endcase
        end
      end
      default: state_next = mlpq_pkg::B_IDLE;
    endcase
  end

  // Any active level occupied after the update
  always_comb begin
    waiting_next = 1'b0;
    for (int k = 0; k < NUM_LEVELS; k++) begin
      if (k < int'(n_active) && cnt_next[k] != '0) waiting_next = 1'b1;
    end
  end

  // Memories: registered reads at accept, writes at update
  always_ff @(posedge clk) begin
    if (take) begin
      tag_rd  <= tag_mem[head[sel]];
      link_rd <= link_mem[head[sel]];
      stk_rd  <= stk_mem[stk_top[AW-1:0]];
    end
    if (tag_we)  tag_mem[tag_wa]   <= cur_tag;
    if (link_we) link_mem[link_wa] <= link_wd;
    if (stk_we)  stk_mem[stk_wa]   <= stk_wd;
  end

  // Command capture and result payload
  always_ff @(posedge clk) begin
    if (take) begin
      cur       <= cmd;
      cur_tag   <= cmd_tag;
      cur_sel   <= sel;
      cur_found <= found;
    end
    if (go) begin
      status      <= status_next;
      out_tag     <= out_tag_next;
      any_waiting <= waiting_next;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= mlpq_pkg::B_IDLE;
      out_valid <= 1'b0;
      stk_cnt   <= '0;
      fresh     <= '0;
      for (int k = 0; k < NUM_LEVELS; k++) begin
        head[k] <= '0;
        tail[k] <= '0;
        cnt[k]  <= '0;
      end
    end else begin
      state   <= state_next;
      stk_cnt <= stk_cnt_next;
      fresh   <= fresh_next;
      for (int k = 0; k < NUM_LEVELS; k++) begin
        head[k] <= head_next[k];
        tail[k] <= tail_next[k];
        cnt[k]  <= cnt_next[k];
      end
      if (go) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  // Returned slots never outnumber slots handed out
  a_stack_bound: assert property (@(posedge clk) disable iff (rst)
    stk_cnt <= fresh) else $error("free stack exceeds allocated slots");

  a_fresh_bound: assert property (@(posedge clk) disable iff (rst)
    fresh <= CW'(CAPACITY)) else $error("fresh slot counter overflow");

  a_result_loaded: assert property (@(posedge clk) disable iff (rst)
    go |=> out_valid) else $error("result not presented after update");

  a_deq_push: assert property (@(posedge clk) disable iff (rst)
    (go && cur.op == mlpq_pkg::OP_DEQ && cur_found) |=> stk_cnt == $past(stk_cnt) + CW'(1))
    else $error("dequeued slot not returned to free stack");

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
// Testbench for multilevel_priority_queue_top: random and directed enqueue,
// dequeue and promote traffic checked against a behavioral queue model.
// Depends on mlpq_pkg and the multilevel_priority_queue_top RTL.
`default_nettype none

module tb_top;

  localparam int NLEV = 8;
  localparam int CAP  = 64;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] tag;
    logic        waiting;
  } qres_t;

  // Behavioral queue model plus pending result store
  class queue_scoreboard;
    logic [15:0] tags [CAP];
    logic [5:0]  link [CAP];
    logic [5:0]  head [NLEV];
    logic [5:0]  tail [NLEV];
    int          cnt [NLEV];
    logic [5:0]  free_stack [CAP];
    int          free_n;
    logic [3:0]  lvl_reg;
    qres_t       pending[$];
    int          errors;

    function new();
      for (int i = 0; i < CAP; i++) begin
        free_stack[i] = i[5:0];
        tags[i] = '0;
        link[i] = '0;
      end
      for (int i = 0; i < NLEV; i++) begin
        head[i] = '0;
        tail[i] = '0;
        cnt[i] = 0;
      end
      free_n = CAP;
      lvl_reg = mlpq_pkg::LEVELS_RESET;
      errors = 0;
    endfunction

    function int active();
      if (lvl_reg < 1) return 1;
      if (lvl_reg > NLEV) return NLEV;
      return lvl_reg;
    endfunction

    function int held();
      int s;
      s = 0;
      for (int i = 0; i < NLEV; i++) s += cnt[i];
      return s;
    endfunction

    function bit waiting();
      for (int i = 0; i < active(); i++)
        if (cnt[i] != 0) return 1;
      return 0;
    endfunction

    // Note an accepted input transaction and queue its expected result
    function void note_input(logic [1:0] op, logic [2:0] lv, logic [15:0] t);
      qres_t r;
      int n, i;
      logic [5:0] s;
      n = active();
      r = '0;
      if (op == mlpq_pkg::OPC_ENQ) begin
        if (lv >= n) r.status = mlpq_pkg::ST_RANGE;
        else if (free_n == 0) r.status = mlpq_pkg::ST_FULL;
        else begin
          free_n--;
          s = free_stack[free_n];
          tags[s] = t;
          link[s] = '0;
          if (cnt[lv] == 0) head[lv] = s;
          else link[tail[lv]] = s;
          tail[lv] = s;
          cnt[lv]++;
        end
      end else if (op == mlpq_pkg::OPC_DEQ) begin
        for (i = 0; i < n; i++)
          if (cnt[i] != 0) break;
        if (i == n) r.status = mlpq_pkg::ST_NONE;
        else begin
          s = head[i];
          r.tag = tags[s];
          cnt[i]--;
          if (cnt[i] == 0) begin
            head[i] = '0;
            tail[i] = '0;
          end else head[i] = link[s];
          if (free_n < CAP) begin
            free_stack[free_n] = s;
            free_n++;
          end
        end
      end else if (op == mlpq_pkg::OPC_PRO) begin
        for (i = 1; i < n; i++) begin
          if (cnt[i] != 0) begin
            if (cnt[i-1] == 0) head[i-1] = head[i];
            else link[tail[i-1]] = head[i];
            tail[i-1] = tail[i];
            cnt[i-1] += cnt[i];
            cnt[i] = 0;
            head[i] = '0;
            tail[i] = '0;
          end
        end
      end
      r.waiting = waiting();
      pending.push_back(r);
    endfunction

    // Compare one output transaction with the oldest expectation
    function void check_result(logic [1:0] st, logic [15:0] t, logic w);
      qres_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result status=%0d tag=%h waiting=%0d", $time, st, t, w);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (st !== e.status) begin
        $display("%0t: status expected %0d actual %0d", $time, e.status, st);
        errors++;
      end
      if (t !== e.tag) begin
        $display("%0t: out_tag expected %h actual %h", $time, e.tag, t);
        errors++;
      end
      if (w !== e.waiting) begin
        $display("%0t: any_waiting expected %0d actual %0d", $time, e.waiting, w);
        errors++;
      end
    endfunction
  endclass

  logic        clk, rst;
  logic        in_valid, in_ready;
  logic [1:0]  opcode;
  logic [2:0]  level;
  logic [15:0] item_tag;
  logic        out_valid, out_ready;
  logic [1:0]  status;
  logic [15:0] out_tag;
  logic        any_waiting;
  logic        cfg_valid, cfg_ready;
  logic [3:0]  cfg_data;

  queue_scoreboard sb;
  bit calm;  // no-idle stretch

  multilevel_priority_queue_top dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .opcode(opcode), .level(level), .item_tag(item_tag),
    .out_valid(out_valid), .out_ready(out_ready),
    .status(status), .out_tag(out_tag), .any_waiting(any_waiting),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Fixed run limit
  initial begin
    #3000000;
    $display("tb_top failed");
    $finish;
  end

  // Output side: random stalls, check each accepted transaction
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) sb.check_result(status, out_tag, any_waiting);
      out_ready <= calm || ($urandom_range(99) >= 9);
    end
  end

  // Valid stays high between back-to-back transactions; drops only on idle
  task automatic send_item(logic [1:0] op, logic [2:0] lv, logic [15:0] t);
    while (!calm && $urandom_range(99) < 9) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    opcode <= op;
    level <= lv;
    item_tag <= t;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_input(op, lv, t);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_levels(logic [3:0] v);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.lvl_reg = v;
    cfg_valid <= 1'b0;
  endtask

  // Random operation mix; biased by fill level
  task automatic random_items(int count);
    int r;
    logic [1:0] op;
    for (int k = 0; k < count; k++) begin
      calm = (k % 300) >= 220;
      r = $urandom_range(99);
      if (sb.held() > 50) begin
        op = (r < 30) ? mlpq_pkg::OPC_ENQ : (r < 90) ? mlpq_pkg::OPC_DEQ : mlpq_pkg::OPC_PRO;
      end else begin
        op = (r < 55) ? mlpq_pkg::OPC_ENQ : (r < 88) ? mlpq_pkg::OPC_DEQ :
             (r < 97) ? mlpq_pkg::OPC_PRO : mlpq_pkg::OPC_UNUSED;
      end
      send_item(op, 3'($urandom_range(7)), 16'($urandom()));
    end
    calm = 0;
  endtask

  initial begin
    sb = new();
    rst = 1'b1;
    in_valid = 1'b0;
    opcode = '0;
    level = '0;
    item_tag = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    calm = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty dequeue, extremes, every opcode, bad level
    send_item(mlpq_pkg::OPC_DEQ, 3'd0, 16'h0);
    send_item(mlpq_pkg::OPC_ENQ, 3'd7, 16'hFFFF);
    send_item(mlpq_pkg::OPC_ENQ, 3'd0, 16'h0000);
    send_item(mlpq_pkg::OPC_ENQ, 3'd1, 16'hA5A5);
    send_item(mlpq_pkg::OPC_ENQ, 3'd1, 16'h5A5A);
    send_item(mlpq_pkg::OPC_PRO, 3'd0, 16'h0);
    send_item(mlpq_pkg::OPC_UNUSED, 3'd7, 16'hFFFF);
    for (int i = 0; i < 5; i++) send_item(mlpq_pkg::OPC_DEQ, 3'd0, 16'h0);
    // Fill the store, then one more for the full case
    for (int i = 0; i < CAP; i++) send_item(mlpq_pkg::OPC_ENQ, i[2:0], i[15:0]);
    send_item(mlpq_pkg::OPC_ENQ, 3'd2, 16'h1234);
    write_levels(4'd1);
    send_item(mlpq_pkg::OPC_ENQ, 3'd1, 16'h1);
    send_item(mlpq_pkg::OPC_PRO, 3'd0, 16'h0);
    send_item(mlpq_pkg::OPC_DEQ, 3'd0, 16'h0);
    write_levels(4'd0);
    send_item(mlpq_pkg::OPC_ENQ, 3'd0, 16'h2);
    write_levels(4'd15);
    send_item(mlpq_pkg::OPC_DEQ, 3'd0, 16'h0);

    // Random phases across several settings
    random_items(300);
    write_levels(4'd3);
    random_items(300);
    write_levels(4'd1);
    random_items(150);
    write_levels(4'd8);
    random_items(300);
    write_levels(4'd2);
    random_items(150);

    drain();
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end
endmodule

`default_nettype wire
